// File: rtl/bgc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the button gesture classifier
package bgc_pkg;

  localparam int NumButtonsDef = 8;
  localparam int TimeBitsDef   = 32;

  localparam int BTN_W  = 3;
  localparam int POS_W  = 16;
  localparam int NOW_W  = 32;
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 2;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd250;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_POLL    = 2'd2;

  localparam logic REG_LONG_PRESS   = 1'b0;
  localparam logic REG_DOUBLE_CLICK = 1'b1;

  typedef enum logic [2:0] {
    EV_DOWN         = 3'd0,
    EV_PRESSED      = 3'd1,
    EV_DOUBLE       = 3'd2,
    EV_UP           = 3'd3,
    EV_LONG_UP      = 3'd4,
    EV_CLICK        = 3'd5,
    EV_LONG_DOWN    = 3'd6,
    EV_LONG_PRESSED = 3'd7
  } ev_kind_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [BTN_W-1:0]        button;
    logic                    held;
    logic [NOW_W-1:0]        now_ms;
    logic signed [POS_W-1:0] cursor_x;
    logic signed [POS_W-1:0] cursor_y;
  } item_t;

  typedef struct packed {
    ev_kind_e                kind0;
    ev_kind_e                kind1;
    ev_kind_e                kind2;
    logic [CNT_W-1:0]        count;
    logic [BTN_W-1:0]        button;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } ev_set_t;

  typedef struct packed {
    logic btn_en;
    logic pressed;
    logic long_fired;
    logic start_wr;
    logic prev_en;
    logic prev_valid;
  } st_upd_t;

endpackage

// File: rtl/bgc_state.sv
`timescale 1ns / 1ps
// per-button press state and previous press record
module bgc_state import bgc_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  st_upd_t              upd_i,
  input  logic [BTN_W-1:0]     button_i,
  input  logic [TIME_BITS-1:0] now_i,
  output logic                 is_pressed_o,
  output logic                 long_fired_o,
  output logic [TIME_BITS-1:0] press_start_o,
  output logic                 prev_valid_o,
  output logic [BTN_W-1:0]     prev_button_o,
  output logic [TIME_BITS-1:0] prev_time_o
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic                 is_pressed_q  [NUM_BUTTONS];
  logic                 long_fired_q  [NUM_BUTTONS];
  logic [TIME_BITS-1:0] press_start_q [NUM_BUTTONS];
  logic                 prev_valid_q;
  logic [BTN_W-1:0]     prev_button_q;
  logic [TIME_BITS-1:0] prev_time_q;
  logic [IDX_W-1:0]     idx;

  assign idx = IDX_W'(button_i);

  assign is_pressed_o  = is_pressed_q[idx];
  assign long_fired_o  = long_fired_q[idx];
  assign press_start_o = press_start_q[idx];
  assign prev_valid_o  = prev_valid_q;
  assign prev_button_o = prev_button_q;
  assign prev_time_o   = prev_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        is_pressed_q[i]  <= 1'b0;
        long_fired_q[i]  <= 1'b0;
        press_start_q[i] <= '0;
      end
      prev_valid_q  <= 1'b0;
      prev_button_q <= '0;
      prev_time_q   <= '0;
    end else if (we_i) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (upd_i.btn_en && idx == IDX_W'(i)) begin
          is_pressed_q[i] <= upd_i.pressed;
          long_fired_q[i] <= upd_i.long_fired;
          if (upd_i.start_wr) begin
            press_start_q[i] <= now_i;
          end
        end
      end
      if (upd_i.prev_en) begin
        prev_valid_q  <= upd_i.prev_valid;
        prev_button_q <= upd_i.prev_valid ? button_i : '0;
        prev_time_q   <= upd_i.prev_valid ? now_i : '0;
      end
    end
  end

endmodule

// File: rtl/bgc_classify.sv
`timescale 1ns / 1ps
// gesture decode of one item into up to three events and a state update
module bgc_classify import bgc_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  item_t                item_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 is_pressed_i,
  input  logic                 long_fired_i,
  input  logic [TIME_BITS-1:0] press_start_i,
  input  logic                 prev_valid_i,
  input  logic [BTN_W-1:0]     prev_button_i,
  input  logic [TIME_BITS-1:0] prev_time_i,
  input  logic [CFG_W-1:0]     long_press_i,
  input  logic [CFG_W-1:0]     double_click_i,
  output ev_set_t              ev_o,
  output st_upd_t              upd_o
);

  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] gap_time;
  logic                 btn_ok;
  logic                 long_reached;
  logic                 dbl;

  assign hold_time    = now_i - press_start_i;
  assign gap_time     = now_i - prev_time_i;
  assign btn_ok       = 32'(item_i.button) < NUM_BUTTONS;
  assign long_reached = hold_time >= TIME_BITS'(long_press_i);
  assign dbl          = prev_valid_i && (prev_button_i == item_i.button) &&
                        (gap_time <= TIME_BITS'(double_click_i));

  always_comb begin
    ev_o        = '0;
    ev_o.kind0  = EV_DOWN;
    ev_o.kind1  = EV_DOWN;
    ev_o.kind2  = EV_DOWN;
    ev_o.button = item_i.button;
    ev_o.x      = item_i.cursor_x;
    ev_o.y      = item_i.cursor_y;
    upd_o       = '0;
    if (btn_ok) begin
      unique case (item_i.action)
        ACT_PRESS: begin
          ev_o.kind0       = EV_DOWN;
          ev_o.kind1       = EV_PRESSED;
          ev_o.kind2       = EV_DOUBLE;
          ev_o.count       = dbl ? CNT_W'(3) : CNT_W'(2);
          upd_o.btn_en     = 1'b1;
          upd_o.pressed    = 1'b1;
          upd_o.long_fired = 1'b0;
          upd_o.start_wr   = 1'b1;
          upd_o.prev_en    = 1'b1;
          upd_o.prev_valid = !dbl;
        end
        ACT_RELEASE: begin
          ev_o.kind0       = EV_UP;
          ev_o.kind1       = long_fired_i ? EV_LONG_UP : EV_CLICK;
          ev_o.count       = is_pressed_i ? CNT_W'(2) : CNT_W'(1);
          upd_o.btn_en     = is_pressed_i;
        end
        ACT_POLL: begin
          if (item_i.held && is_pressed_i) begin
            ev_o.kind0 = EV_PRESSED;
            if (long_fired_i) begin
              ev_o.kind1 = EV_LONG_PRESSED;
              ev_o.count = CNT_W'(2);
            end else if (long_reached) begin
              ev_o.kind1       = EV_LONG_DOWN;
              ev_o.kind2       = EV_LONG_PRESSED;
              ev_o.count       = CNT_W'(3);
              upd_o.btn_en     = 1'b1;
              upd_o.pressed    = 1'b1;
              upd_o.long_fired = 1'b1;
            end else begin
              ev_o.count = CNT_W'(1);
            end
          end
        end
        default: begin
          ev_o.count = '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/bgc_seq.sv
`timescale 1ns / 1ps
// result register that hands out the events of one item one per transfer
module bgc_seq import bgc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  ev_set_t                 set_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ev_kind_e                kind_o,
  output logic [BTN_W-1:0]        button_o,
  output logic signed [POS_W-1:0] x_o,
  output logic signed [POS_W-1:0] y_o,
  output logic                    last_o
);

  logic             valid_q;
  logic [CNT_W-1:0] idx_q;
  ev_set_t          set_q;
  logic             last;

  assign last        = idx_q == (set_q.count - CNT_W'(1));
  assign ready_o     = !valid_q || (out_ready_i && last);
  assign out_valid_o = valid_q;
  assign button_o    = set_q.button;
  assign x_o         = set_q.x;
  assign y_o         = set_q.y;
  assign last_o      = last;

  always_comb begin
    case (idx_q)
      CNT_W'(0): kind_o = set_q.kind0;
      CNT_W'(1): kind_o = set_q.kind1;
      default:   kind_o = set_q.kind2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= set_i.count != '0;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      set_q <= set_i;
    end
  end

endmodule

// File: rtl/button_gesture_classifier_unit.sv
`timescale 1ns / 1ps
// top level of the button gesture classifier
//
// usage: each input transfer carries one press, release or hold poll of one
// button with a millisecond timestamp and the cursor position. the block
// answers with zero to three gesture events on the output channel, one event
// per transfer, with last_event marking the final event of that input.
// an accepted input is held in the input register and, once the result register
// can take it, is decoded against the button state into the result register,
// from which its first event is offered on the output channel.
// throughput: while the output is not stalled, the result register sends one
// event per cycle, one to three per input; an input without events leaves it
// empty. the input register takes a new item while the result register still
// holds events for the previous one.
// a stalled output holds the current event steady; the input register fills
// and then input ready drops until the last event is taken.
// reset clears all button state, the previous press record and both pending
// stages, and loads the long press and double click times with 500 and 250.
// configuration: apb writes at byte address 0 (long press) and 4 (double
// click), to be done while the block is idle.
module button_gesture_classifier_unit import bgc_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [BTN_W-1:0]        button_i,
  input  logic                    held_i,
  input  logic [NOW_W-1:0]        now_ms_i,
  input  logic signed [POS_W-1:0] cursor_x_i,
  input  logic signed [POS_W-1:0] cursor_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              event_kind_o,
  output logic [BTN_W-1:0]        event_button_o,
  output logic signed [POS_W-1:0] event_x_o,
  output logic signed [POS_W-1:0] event_y_o,
  output logic                    last_event_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  logic                 inq_valid_q;
  item_t                inq_q;
  logic                 seq_ready;
  logic                 move;
  logic [TIME_BITS-1:0] now_t;
  logic [CFG_W-1:0]     long_press_q;
  logic [CFG_W-1:0]     double_click_q;
  logic                 is_pressed;
  logic                 long_fired;
  logic [TIME_BITS-1:0] press_start;
  logic                 prev_valid;
  logic [BTN_W-1:0]     prev_button;
  logic [TIME_BITS-1:0] prev_time;
  ev_set_t              ev_set;
  st_upd_t              upd;
  ev_kind_e             kind;

  assign move       = inq_valid_q && seq_ready;
  assign in_ready_o = !inq_valid_q || seq_ready;
  assign now_t      = TIME_BITS'(inq_q.now_ms);
  assign pready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inq_valid_q <= 1'b1;
    end else if (move) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_q.action   <= action_i;
      inq_q.button   <= button_i;
      inq_q.held     <= held_i;
      inq_q.now_ms   <= now_ms_i;
      inq_q.cursor_x <= cursor_x_i;
      inq_q.cursor_y <= cursor_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= LONG_PRESS_RST;
      double_click_q <= DOUBLE_CLICK_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LONG_PRESS:   long_press_q   <= pwdata[CFG_W-1:0];
        REG_DOUBLE_CLICK: double_click_q <= pwdata[CFG_W-1:0];
        default:          long_press_q   <= long_press_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LONG_PRESS:   prdata = APB_DW'(long_press_q);
      REG_DOUBLE_CLICK: prdata = APB_DW'(double_click_q);
      default:          prdata = '0;
    endcase
  end

  bgc_state #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (move),
    .upd_i         (upd),
    .button_i      (inq_q.button),
    .now_i         (now_t),
    .is_pressed_o  (is_pressed),
    .long_fired_o  (long_fired),
    .press_start_o (press_start),
    .prev_valid_o  (prev_valid),
    .prev_button_o (prev_button),
    .prev_time_o   (prev_time)
  );

  bgc_classify #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_classify (
    .item_i         (inq_q),
    .now_i          (now_t),
    .is_pressed_i   (is_pressed),
    .long_fired_i   (long_fired),
    .press_start_i  (press_start),
    .prev_valid_i   (prev_valid),
    .prev_button_i  (prev_button),
    .prev_time_i    (prev_time),
    .long_press_i   (long_press_q),
    .double_click_i (double_click_q),
    .ev_o           (ev_set),
    .upd_o          (upd)
  );

  bgc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move),
    .set_i       (ev_set),
    .ready_o     (seq_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind),
    .button_o    (event_button_o),
    .x_o         (event_x_o),
    .y_o         (event_y_o),
    .last_o      (last_event_o)
  );

  assign event_kind_o = kind;

`ifndef SYNTHESIS
  a_more_events_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_event_o) |=> out_valid_o)
    else $error("event sequence broken before its last event");

  a_button_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_event_o) |=>
      (event_button_o == $past(event_button_o)))
    else $error("button changed within one item's events");

  a_closing_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == EV_DOUBLE || event_kind_o == EV_CLICK ||
      event_kind_o == EV_LONG_UP)) |-> last_event_o)
    else $error("closing event kind not marked last");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> inq_valid_q)
    else $error("accepted item lost from input register");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the button gesture classifier
module testbench;
  import bgc_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    ev_kind_e                kind;
    logic [BTN_W-1:0]        button;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    last;
  } gesture_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              action_i = ACT_PRESS;
  logic [BTN_W-1:0]        button_i = '0;
  logic                    held_i = 1'b0;
  logic [NOW_W-1:0]        now_ms_i = '0;
  logic signed [POS_W-1:0] cursor_x_i = '0;
  logic signed [POS_W-1:0] cursor_y_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [2:0]              event_kind_o;
  logic [BTN_W-1:0]        event_button_o;
  logic signed [POS_W-1:0] event_x_o;
  logic signed [POS_W-1:0] event_y_o;
  logic                    last_event_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  button_gesture_classifier_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .button_i      (button_i),
    .held_i        (held_i),
    .now_ms_i      (now_ms_i),
    .cursor_x_i    (cursor_x_i),
    .cursor_y_i    (cursor_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .event_button_o(event_button_o),
    .event_x_o     (event_x_o),
    .event_y_o     (event_y_o),
    .last_event_o  (last_event_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // gesture state as the block should hold it
  logic              btn_down   [NumButtonsDef];
  logic              long_done  [NumButtonsDef];
  logic [NOW_W-1:0]  down_since [NumButtonsDef];
  logic [BTN_W-1:0]  last_press_btn = '0;
  logic              last_press_valid = 1'b0;
  logic [NOW_W-1:0]  last_press_time = '0;
  logic [CFG_W-1:0]  cfg_long = LONG_PRESS_RST;
  logic [CFG_W-1:0]  cfg_double = DOUBLE_CLICK_RST;

  item_t     item_queue[$];
  gesture_t  gesture_queue[$];
  logic      in_taken = 1'b0;
  logic      idle_on = 1'b1;
  int        send_gap = 0;
  int        hold_cnt = 0;
  int        cycles = 0;
  int        n_mismatch = 0;
  logic [NOW_W-1:0] t_clock = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (n_mismatch < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycles, msg);
    n_mismatch++;
  endtask

  function automatic void predict_gestures(input item_t it);
    ev_kind_e         kinds[3];
    int               n;
    logic [NOW_W-1:0] gap;
    gesture_t         g;
    n = 0;
    if (it.action == ACT_PRESS) begin
      btn_down[it.button] = 1'b1;
      long_done[it.button] = 1'b0;
      down_since[it.button] = it.now_ms;
      kinds[0] = EV_DOWN;
      kinds[1] = EV_PRESSED;
      n = 2;
      gap = it.now_ms - last_press_time;
      if (last_press_valid && last_press_btn == it.button && gap <= NOW_W'(cfg_double)) begin
        kinds[2] = EV_DOUBLE;
        n = 3;
        last_press_valid = 1'b0;
        last_press_btn = '0;
        last_press_time = '0;
      end else begin
        last_press_valid = 1'b1;
        last_press_btn = it.button;
        last_press_time = it.now_ms;
      end
    end else if (it.action == ACT_RELEASE) begin
      kinds[0] = EV_UP;
      n = 1;
      if (btn_down[it.button]) begin
        kinds[1] = long_done[it.button] ? EV_LONG_UP : EV_CLICK;
        n = 2;
        btn_down[it.button] = 1'b0;
        long_done[it.button] = 1'b0;
      end
    end else if (it.action == ACT_POLL && it.held && btn_down[it.button]) begin
      kinds[0] = EV_PRESSED;
      n = 1;
      gap = it.now_ms - down_since[it.button];
      if (!long_done[it.button]) begin
        if (NOW_W'(cfg_long) <= gap) begin
          kinds[1] = EV_LONG_DOWN;
          kinds[2] = EV_LONG_PRESSED;
          n = 3;
          long_done[it.button] = 1'b1;
        end
      end else begin
        kinds[1] = EV_LONG_PRESSED;
        n = 2;
      end
    end
    for (int i = 0; i < n; i++) begin
      g.kind = kinds[i];
      g.button = it.button;
      g.x = it.cursor_x;
      g.y = it.cursor_y;
      g.last = (i == n - 1);
      gesture_queue.push_back(g);
    end
  endfunction

  // acceptance, prediction and result checking
  always @(posedge clk_i) begin
    gesture_t g;
    item_t    it;
    if (rst_ni) begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        it.action = action_i;
        it.button = button_i;
        it.held = held_i;
        it.now_ms = now_ms_i;
        it.cursor_x = cursor_x_i;
        it.cursor_y = cursor_y_i;
        predict_gestures(it);
      end
      if (out_valid_o && out_ready_i) begin
        if (gesture_queue.size() == 0) begin
          flag_mismatch($sformatf("event kind %0d button %0d with none expected",
                                  event_kind_o, event_button_o));
        end else begin
          g = gesture_queue.pop_front();
          if (event_kind_o !== g.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", event_kind_o, g.kind));
          if (event_button_o !== g.button)
            flag_mismatch($sformatf("button %0d, expected %0d", event_button_o, g.button));
          if (event_x_o !== g.x)
            flag_mismatch($sformatf("x %0d, expected %0d", event_x_o, g.x));
          if (event_y_o !== g.y)
            flag_mismatch($sformatf("y %0d, expected %0d", event_y_o, g.y));
          if (last_event_o !== g.last)
            flag_mismatch($sformatf("last %0b, expected %0b", last_event_o, g.last));
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    item_t cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (item_queue.size() > 0) begin
        cur = item_queue.pop_front();
        action_i <= cur.action;
        button_i <= cur.button;
        held_i <= cur.held;
        now_ms_i <= cur.now_ms;
        cursor_x_i <= cur.cursor_x;
        cursor_y_i <= cur.cursor_y;
        in_valid_i <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_cnt = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [BTN_W-1:0] btn,
                            input logic hld, input logic [NOW_W-1:0] now,
                            input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y);
    item_t it;
    it.action = act;
    it.button = btn;
    it.held = hld;
    it.now_ms = now;
    it.cursor_x = x;
    it.cursor_y = y;
    item_queue.push_back(it);
  endtask

  task automatic queue_step(input logic [1:0] act, input logic [BTN_W-1:0] btn,
                            input logic hld, input logic [NOW_W-1:0] dt);
    t_clock = t_clock + dt;
    queue_item(act, btn, hld, t_clock, POS_W'($urandom), POS_W'($urandom));
  endtask

  function automatic logic [NOW_W-1:0] noise_dt();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(0, int'(cfg_long) + int'(cfg_double) + 2);
      default: return $urandom_range(0, 10);
    endcase
  endfunction

  function automatic logic [BTN_W-1:0] pick_button();
    if ($urandom_range(0, 3) == 0) return BTN_W'($urandom_range(0, NumButtonsDef - 1));
    return BTN_W'($urandom_range(0, 1));
  endfunction

  task automatic queue_random_items(input int count);
    int               made;
    int               k;
    int               lp;
    int               dbl;
    logic [BTN_W-1:0] b;
    logic [BTN_W-1:0] b2;
    made = 0;
    lp = int'(cfg_long);
    dbl = int'(cfg_double);
    while (made < count) begin
      b = pick_button();
      case ($urandom_range(0, 5))
        0: begin
          queue_step(ACT_PRESS, b, 1'b1, noise_dt());
          k = $urandom_range(0, 2);
          for (int i = 0; i < k; i++) queue_step(ACT_POLL, b, 1'b1, $urandom_range(0, lp / 4 + 1));
          queue_step(ACT_RELEASE, b, 1'b1, $urandom_range(0, lp / 4 + 1));
          made += 2 + k;
        end
        1: begin
          queue_step(ACT_PRESS, b, 1'b1, noise_dt());
          queue_step(ACT_RELEASE, b, 1'b1, $urandom_range(0, dbl / 2));
          queue_step(ACT_PRESS, b, 1'b1, $urandom_range(0, dbl / 2 + 4));
          queue_step(ACT_RELEASE, b, 1'b1, $urandom_range(0, dbl));
          made += 4;
        end
        2: begin
          queue_step(ACT_PRESS, b, 1'b1, noise_dt());
          k = $urandom_range(2, 5);
          for (int i = 0; i < k; i++)
            queue_step(ACT_POLL, b, 1'b1, $urandom_range(lp / 4, lp / 2 + 1));
          queue_step(ACT_RELEASE, b, 1'b1, $urandom_range(0, lp / 4 + 1));
          made += 2 + k;
        end
        3: begin
          b2 = pick_button();
          queue_step(ACT_PRESS, b, 1'b1, noise_dt());
          queue_step(ACT_PRESS, b2, 1'b1, $urandom_range(0, lp / 3 + 1));
          queue_step(ACT_POLL, b, 1'b1, $urandom_range(0, lp / 3 + 1));
          queue_step(ACT_POLL, b2, 1'($urandom_range(0, 1)), $urandom_range(0, lp / 3 + 1));
          queue_step(ACT_RELEASE, b2, 1'b1, $urandom_range(0, lp / 3 + 1));
          queue_step(ACT_RELEASE, b, 1'b1, $urandom_range(0, lp / 3 + 1));
          made += 6;
        end
        default: begin
          queue_step(2'($urandom_range(0, 3)), BTN_W'($urandom_range(0, NumButtonsDef - 1)),
                     1'($urandom_range(0, 1)), noise_dt());
          made += 1;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (item_queue.size() != 0 || in_valid_i || gesture_queue.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_LONG_PRESS) cfg_long = val;
    else cfg_double = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dbl);
    wait_drained();
    apb_write(REG_LONG_PRESS, lp);
    apb_write(REG_DOUBLE_CLICK, dbl);
    @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NumButtonsDef; i++) begin
      btn_down[i] = 1'b0;
      long_done[i] = 1'b0;
      down_since[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // double click window edges, cleared record, release without press
    queue_item(ACT_PRESS, 3'd0, 1'b0, 32'd1000, 16'sd0, 16'sd0);
    queue_item(ACT_PRESS, 3'd0, 1'b1, 32'd1250, 16'sd1, -16'sd1);
    queue_item(ACT_PRESS, 3'd0, 1'b0, 32'd1300, 16'sd2, 16'sd2);
    queue_item(ACT_RELEASE, 3'd0, 1'b0, 32'd1310, 16'sd3, 16'sd3);
    queue_item(ACT_PRESS, 3'd0, 1'b1, 32'd1551, 16'sd4, 16'sd4);
    queue_item(ACT_POLL, 3'd1, 1'b1, 32'd1600, 16'sd5, 16'sd5);
    queue_item(ACT_RELEASE, 3'd3, 1'b1, 32'd1610, 16'sd6, 16'sd6);
    queue_item(ACT_NONE, 3'd0, 1'b1, 32'd1620, 16'sd7, 16'sd7);
    // long press threshold edges and cursor extremes
    queue_item(ACT_PRESS, 3'd7, 1'b1, 32'h10, -16'sd32768, 16'sd32767);
    queue_item(ACT_POLL, 3'd7, 1'b0, 32'h200, 16'sd8, 16'sd8);
    queue_item(ACT_POLL, 3'd7, 1'b1, 32'h10 + 32'd499, 16'sd9, 16'sd9);
    queue_item(ACT_POLL, 3'd7, 1'b1, 32'h10 + 32'd500, 16'sd10, 16'sd10);
    queue_item(ACT_POLL, 3'd7, 1'b1, 32'h10 + 32'd600, 16'sd11, 16'sd11);
    queue_item(ACT_RELEASE, 3'd7, 1'b1, 32'h300, 16'sd32767, -16'sd32768);
    // press while already pressed restarts the hold
    queue_item(ACT_PRESS, 3'd5, 1'b1, 32'd5000, 16'sd12, 16'sd12);
    queue_item(ACT_POLL, 3'd5, 1'b1, 32'd5400, 16'sd13, 16'sd13);
    queue_item(ACT_PRESS, 3'd5, 1'b1, 32'd5450, 16'sd14, 16'sd14);
    queue_item(ACT_POLL, 3'd5, 1'b1, 32'd5900, 16'sd15, 16'sd15);
    queue_item(ACT_POLL, 3'd5, 1'b1, 32'd5950, 16'sd16, 16'sd16);
    // time wrap for hold and for double click
    queue_item(ACT_PRESS, 3'd2, 1'b1, 32'hFFFF_FF00, 16'sd17, 16'sd17);
    queue_item(ACT_POLL, 3'd2, 1'b1, 32'h0000_0100, 16'sd18, 16'sd18);
    queue_item(ACT_RELEASE, 3'd2, 1'b1, 32'h0000_0101, 16'sd19, 16'sd19);
    queue_item(ACT_PRESS, 3'd2, 1'b1, 32'hFFFF_FFFF, -16'sd1, -16'sd1);
    queue_item(ACT_PRESS, 3'd2, 1'b1, 32'h0000_00F9, 16'sd20, 16'sd20);

    // zero windows: same-time double and immediate long press
    set_timing(16'd0, 16'd0);
    queue_item(ACT_PRESS, 3'd4, 1'b1, 32'd100, 16'sd21, 16'sd21);
    queue_item(ACT_PRESS, 3'd4, 1'b1, 32'd100, 16'sd22, 16'sd22);
    queue_item(ACT_POLL, 3'd4, 1'b1, 32'd100, 16'sd23, 16'sd23);
    queue_item(ACT_PRESS, 3'd6, 1'b1, 32'd200, 16'sd24, 16'sd24);
    queue_item(ACT_PRESS, 3'd6, 1'b1, 32'd201, 16'sd25, 16'sd25);
    queue_item(ACT_RELEASE, 3'd4, 1'b1, 32'd202, 16'sd26, 16'sd26);

    set_timing(CFG_W'($urandom_range(1, 1500)), CFG_W'($urandom_range(1, 800)));
    queue_random_items(55);
    set_timing(16'hFFFF, 16'hFFFF);
    idle_on = 1'b0;
    queue_random_items(55);
    set_timing(16'd0, 16'd0);
    idle_on = 1'b1;
    queue_random_items(55);
    set_timing(16'($urandom), 16'($urandom));
    queue_random_items(55);
    set_timing(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 32)));
    queue_random_items(55);
    set_timing(CFG_W'($urandom_range(100, 2000)), CFG_W'($urandom_range(50, 600)));
    idle_on = 1'b0;
    queue_random_items(55);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
